FILE: design/icmp_echo_pkg.sv
// ----------------------------------------------------------------------------
// ICMP echo responder package
// Shared constants, frame layout positions, helper functions and the
// command and status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package icmp_echo_pkg;

   // Buffer depth for the header, up to and including the ICMP checksum word.
   localparam int HEADER_WORDS   = 39;
   // Saturation point of the word counter.
   localparam int POSITION_LIMIT = 1023;

   localparam int WORD_W = 16;
   localparam int AW     = $clog2(HEADER_WORDS);
   localparam int PW     = $clog2(POSITION_LIMIT + 1);
   localparam int IHL_W  = 4;
   localparam int SUM_W  = 22;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;
   localparam logic REG_OWN_IP  = 1'b0;
   localparam logic REG_OWN_MAC = 1'b1;

   // Word positions in the frame.
   localparam int POS_MAC_SRC0 = 3;
   localparam int POS_MAC_SRC1 = 4;
   localparam int POS_MAC_SRC2 = 5;
   localparam int POS_IHL      = 7;
   localparam int POS_IP_CSUM  = 12;
   localparam int POS_SRC_HI   = 13;
   localparam int POS_SRC_LO   = 14;
   localparam int POS_DST_HI   = 15;
   localparam int POS_DST_LO   = 16;
   localparam int TYPE_BASE    = 7;
   localparam int NEED_BASE    = 9;
   localparam int MIN_IHL      = 5;

   // ICMP codes and checksum adjust constants.
   localparam logic [7:0] ICMP_ECHO_REQUEST = 8'h08;
   localparam logic [7:0] ICMP_ECHO_REPLY   = 8'h00;
   localparam logic [7:0] CSUM_HI_INC       = 8'h08;
   localparam logic [7:0] CSUM_HI_LIMIT     = 8'hFF - 8'h08;
   localparam logic [3:0] IHL_MASK          = 4'h0F;

   // Controller to datapath commands.
   typedef struct packed {
      logic          store_we;
      logic [AW-1:0] store_addr;
      logic [AW-1:0] rd_addr;
      logic          sum_clear;
      logic          sum_add;
      logic          type_load;
      logic          csum_load;
      logic          emit_load;
      logic [AW-1:0] emit_idx;
      logic [AW-1:0] type_pos;
      logic          emit_last;
      logic          pass_load;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_free;
      logic is_echo;
   } status_type;

   // Number of words up to and including the ICMP checksum word.
   function automatic logic [PW-1:0] header_need(input logic [IHL_W-1:0] ihl);
      return PW'(NEED_BASE) + PW'({ihl, 1'b0});
   endfunction

   // Position of the ICMP type word.
   function automatic logic [PW-1:0] type_pos(input logic [IHL_W-1:0] ihl);
      return PW'(TYPE_BASE) + PW'({ihl, 1'b0});
   endfunction

endpackage

FILE: design/icmp_echo_req_if.sv
// ----------------------------------------------------------------------------
// Request frame channel
// Valid/ready channel carrying one 16-bit frame word per beat.
// ----------------------------------------------------------------------------
interface icmp_echo_req_if;
   logic                              valid;
   logic                              ready;
   logic [icmp_echo_pkg::WORD_W-1:0]  frame_word;
   logic                              frame_last;
   logic                              odd_tail;

   modport source (output valid, frame_word, frame_last, odd_tail, input ready);
   modport sink   (input valid, frame_word, frame_last, odd_tail, output ready);
endinterface

FILE: design/icmp_echo_rsp_if.sv
// ----------------------------------------------------------------------------
// Reply frame channel
// Valid/ready channel carrying one 16-bit reply word per beat.
// ----------------------------------------------------------------------------
interface icmp_echo_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [icmp_echo_pkg::WORD_W-1:0]  reply_word;
   logic                              reply_last;
   logic                              reply_odd_tail;

   modport source (output valid, reply_word, reply_last, reply_odd_tail, input ready);
   modport sink   (input valid, reply_word, reply_last, reply_odd_tail, output ready);
endinterface

FILE: design/icmp_echo_csr.sv
// ----------------------------------------------------------------------------
// ICMP echo responder register file
// APB-style port holding the own IPv4 and own MAC address registers.
// ----------------------------------------------------------------------------
module icmp_echo_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [icmp_echo_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [icmp_echo_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [icmp_echo_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready,
   output logic [31:0]                           own_ip,
   output logic [47:0]                           own_mac
);

   logic [31:0] own_ip_ff, own_ip_in;
   logic [47:0] own_mac_ff, own_mac_in;
   logic        wr_en;

   // Registers sit 8 bytes apart; address bit 3 selects the register.
   assign wr_en = psel && penable && pwrite;

   always_comb begin
      own_ip_in  = own_ip_ff;
      own_mac_in = own_mac_ff;
      if (wr_en) begin
         unique case (paddr[3])
            icmp_echo_pkg::REG_OWN_IP:  own_ip_in  = pwdata[31:0];
            icmp_echo_pkg::REG_OWN_MAC: own_mac_in = pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else begin
         own_ip_ff  <= own_ip_in;
         own_mac_ff <= own_mac_in;
      end
   end

   // Read data is returned in the access cycle.
   always_comb begin
      unique case (paddr[3])
         icmp_echo_pkg::REG_OWN_IP:  prdata = {32'b0, own_ip_ff};
         icmp_echo_pkg::REG_OWN_MAC: prdata = {16'b0, own_mac_ff};
         default:                    prdata = '0;
      endcase
   end

   assign pready  = 1'b1;
   assign own_ip  = own_ip_ff;
   assign own_mac = own_mac_ff;

endmodule

FILE: design/icmp_echo_dp.sv
// ----------------------------------------------------------------------------
// ICMP echo responder datapath
// Header buffer, header checksum accumulator, reply word rewrite and the
// output register.
// ----------------------------------------------------------------------------
module icmp_echo_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  icmp_echo_pkg::cmd_type             cmd,
   output icmp_echo_pkg::status_type          status,
   input  logic [icmp_echo_pkg::WORD_W-1:0]   req_word,
   input  logic                               req_last,
   input  logic                               req_odd,
   input  logic [31:0]                        own_ip,
   input  logic [47:0]                        own_mac,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [icmp_echo_pkg::WORD_W-1:0]   rsp_word,
   output logic                               rsp_last,
   output logic                               rsp_odd
);

   localparam int WW  = icmp_echo_pkg::WORD_W;
   localparam int SW  = icmp_echo_pkg::SUM_W;
   localparam int AWL = icmp_echo_pkg::AW;
   typedef logic [AWL-1:0] aw_type;

   logic [WW-1:0] store_mem [icmp_echo_pkg::HEADER_WORDS];
   logic [WW-1:0] rd_data_ff;
   logic [SW-1:0] sum_ff, sum_in;
   logic [7:0]    type_ff;
   logic [WW-1:0] csum_ff;
   logic [SW-1:0] csum_total;
   logic [16:0]   csum_fold1;
   logic [16:0]   csum_fold2;
   logic [7:0]    adj_hi, adj_lo;
   logic [WW-1:0] emit_word;
   logic          out_free;
   logic          is_echo;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0] rsp_word_ff;
   logic          rsp_last_ff, rsp_odd_ff;

   // Header buffer with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store_we) begin
         store_mem[cmd.store_addr] <= req_word;
      end
      rd_data_ff <= store_mem[cmd.rd_addr];
   end

   // Running sum of the IP header words that survive the rewrite.
   always_comb begin
      sum_in = sum_ff;
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (cmd.sum_add) begin
         sum_in = sum_ff + SW'(req_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // ICMP type byte, checked when the checksum word arrives.
   always_ff @(posedge clock) begin
      if (cmd.type_load) begin
         type_ff <= req_word[15:8];
      end
   end

   assign is_echo = (type_ff == icmp_echo_pkg::ICMP_ECHO_REQUEST);

   // Add the new source address, fold twice and complement.
   assign csum_total = sum_ff + SW'(own_ip[31:16]) + SW'(own_ip[15:0]);
   assign csum_fold1 = 17'(csum_total[15:0]) + 17'(csum_total[SW-1:16]);
   assign csum_fold2 = 17'(csum_fold1[15:0]) + 17'(csum_fold1[16]);

   always_ff @(posedge clock) begin
      if (cmd.csum_load) begin
         csum_ff <= ~csum_fold2[15:0];
      end
   end

   // Byte-wise adjust of the ICMP checksum for the type change.
   always_comb begin
      adj_hi = rd_data_ff[15:8] + icmp_echo_pkg::CSUM_HI_INC;
      adj_lo = rd_data_ff[7:0];
      if (rd_data_ff[15:8] > icmp_echo_pkg::CSUM_HI_LIMIT) begin
         adj_lo = rd_data_ff[7:0] + 8'd1;
      end
   end

   // Select the rewritten header word for the current emit index.
   always_comb begin
      if (cmd.emit_idx == aw_type'(icmp_echo_pkg::POS_MAC_SRC0)) begin
         emit_word = own_mac[47:32];
      end else if (cmd.emit_idx == aw_type'(icmp_echo_pkg::POS_MAC_SRC1)) begin
         emit_word = own_mac[31:16];
      end else if (cmd.emit_idx == aw_type'(icmp_echo_pkg::POS_MAC_SRC2)) begin
         emit_word = own_mac[15:0];
      end else if (cmd.emit_idx == aw_type'(icmp_echo_pkg::POS_IP_CSUM)) begin
         emit_word = csum_ff;
      end else if (cmd.emit_idx == aw_type'(icmp_echo_pkg::POS_SRC_HI)) begin
         emit_word = own_ip[31:16];
      end else if (cmd.emit_idx == aw_type'(icmp_echo_pkg::POS_SRC_LO)) begin
         emit_word = own_ip[15:0];
      end else if (cmd.emit_idx == cmd.type_pos) begin
         emit_word = {icmp_echo_pkg::ICMP_ECHO_REPLY, 8'h00};
      end else if (cmd.emit_idx == cmd.type_pos + aw_type'(1)) begin
         emit_word = {adj_hi, adj_lo};
      end else begin
         emit_word = rd_data_ff;
      end
   end

   // Output register: a new beat loads when the register is empty or drains.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status   = '{out_free: out_free, is_echo: is_echo};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_load || cmd.pass_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_word_ff <= emit_word;
         rsp_last_ff <= cmd.emit_last;
         rsp_odd_ff  <= 1'b0;
      end else if (cmd.pass_load) begin
         rsp_word_ff <= req_word;
         rsp_last_ff <= req_last;
         rsp_odd_ff  <= req_odd && req_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_odd   = rsp_odd_ff;

endmodule

FILE: design/icmp_echo_ctrl.sv
// ----------------------------------------------------------------------------
// ICMP echo responder controller
// Frame state machine: header collection, checksum, reply emission,
// payload streaming and discarding of dropped frames.
// ----------------------------------------------------------------------------
module icmp_echo_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_last,
   input  logic                                 req_odd,
   input  logic [icmp_echo_pkg::IHL_W-1:0]      req_ihl,
   output icmp_echo_pkg::cmd_type               cmd,
   input  icmp_echo_pkg::status_type            status
);

   localparam int PW = icmp_echo_pkg::PW;
   localparam int AW = icmp_echo_pkg::AW;
   localparam int IW = icmp_echo_pkg::IHL_W;

   localparam logic [2:0] S_COLLECT = 3'd0;
   localparam logic [2:0] S_STREAM  = 3'd1;
   localparam logic [2:0] S_DISCARD = 3'd2;
   localparam logic [2:0] S_CSUM    = 3'd3;
   localparam logic [2:0] S_EMIT_RD = 3'd4;
   localparam logic [2:0] S_EMIT_WR = 3'd5;

   logic [2:0]                        state_ff, state_in;
   logic [PW-1:0]                     pos_ff, pos_in;
   logic [icmp_echo_pkg::IHL_W-1:0]   ihl_ff, ihl_in;
   logic [AW-1:0]                     idx_ff, idx_in;
   logic                              last_ff, last_in;
   logic [icmp_echo_pkg::IHL_W-1:0]   ihl_eff;
   logic [PW-1:0]                     need_eff, tpos_eff, need_cur, tpos_cur;
   logic [AW-1:0]                     rd_addr;
   logic                              is_final_emit;
   logic                              odd;
   logic                              in_ip_sum;
   logic                              bad_ihl;

   // IHL of the current word: the nibble arrives with word seven.
   assign ihl_eff  = (pos_ff == PW'(icmp_echo_pkg::POS_IHL))
                     ? (req_ihl & icmp_echo_pkg::IHL_MASK) : ihl_ff;
   assign need_eff = icmp_echo_pkg::header_need(ihl_eff);
   assign tpos_eff = icmp_echo_pkg::type_pos(ihl_eff);
   assign need_cur = icmp_echo_pkg::header_need(ihl_ff);
   assign tpos_cur = icmp_echo_pkg::type_pos(ihl_ff);
   assign odd      = req_odd && req_last;
   assign bad_ihl  = (ihl_eff < IW'(icmp_echo_pkg::MIN_IHL))
                     || (need_eff > PW'(icmp_echo_pkg::HEADER_WORDS));

   // IP header words summed: all but the checksum and destination address.
   assign in_ip_sum = (pos_ff >= PW'(icmp_echo_pkg::POS_IHL)) && (pos_ff < tpos_eff)
                      && (pos_ff != PW'(icmp_echo_pkg::POS_IP_CSUM))
                      && (pos_ff != PW'(icmp_echo_pkg::POS_DST_HI))
                      && (pos_ff != PW'(icmp_echo_pkg::POS_DST_LO));

   assign is_final_emit = (PW'(idx_ff) + PW'(1)) == need_cur;

   // Read address for reply word: MAC and IP addresses swap places.
   always_comb begin
      if (idx_ff < AW'(icmp_echo_pkg::POS_MAC_SRC0)) begin
         rd_addr = idx_ff + AW'(icmp_echo_pkg::POS_MAC_SRC0);
      end else if ((idx_ff == AW'(icmp_echo_pkg::POS_DST_HI))
                   || (idx_ff == AW'(icmp_echo_pkg::POS_DST_LO))) begin
         rd_addr = idx_ff - AW'(2);
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      ihl_in         = ihl_ff;
      idx_in         = idx_ff;
      last_in        = last_ff;
      req_ready      = 1'b0;
      cmd.store_we   = 1'b0;
      cmd.store_addr = pos_ff[AW-1:0];
      cmd.rd_addr    = rd_addr;
      cmd.sum_clear  = 1'b0;
      cmd.sum_add    = 1'b0;
      cmd.type_load  = 1'b0;
      cmd.csum_load  = 1'b0;
      cmd.emit_load  = 1'b0;
      cmd.emit_idx   = idx_ff;
      cmd.type_pos   = tpos_cur[AW-1:0];
      cmd.emit_last  = is_final_emit && last_ff;
      cmd.pass_load  = 1'b0;

      unique case (state_ff)
         S_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_we = (pos_ff < PW'(icmp_echo_pkg::HEADER_WORDS));
               if (pos_ff == PW'(icmp_echo_pkg::POS_IHL)) begin
                  ihl_in = ihl_eff;
               end
               if ((pos_ff == PW'(icmp_echo_pkg::POS_IHL)) && bad_ihl) begin
                  // Short or oversize header: drop the frame.
                  if (req_last) begin
                     state_in = S_COLLECT;
                     pos_in = '0;
                     ihl_in = '0;
                     cmd.sum_clear = 1'b1;
                  end else begin
                     state_in = S_DISCARD;
                  end
               end else if ((pos_ff >= PW'(icmp_echo_pkg::POS_IHL))
                            && ((pos_ff + PW'(1)) == need_eff)) begin
                  // ICMP checksum word: the header is complete.
                  if (odd || !status.is_echo) begin
                     if (req_last) begin
                        state_in = S_COLLECT;
                        pos_in = '0;
                        ihl_in = '0;
                        cmd.sum_clear = 1'b1;
                     end else begin
                        state_in = S_DISCARD;
                     end
                  end else begin
                     state_in = S_CSUM;
                     last_in  = req_last;
                     pos_in   = pos_ff + PW'(1);
                  end
               end else begin
                  cmd.sum_add   = in_ip_sum;
                  cmd.type_load = (pos_ff == tpos_eff);
                  if (req_last) begin
                     state_in = S_COLLECT;
                     pos_in = '0;
                     ihl_in = '0;
                     cmd.sum_clear = 1'b1;
                  end else begin
                     pos_in = pos_ff + PW'(1);
                  end
               end
            end
         end
         S_STREAM: begin
            req_ready = status.out_free;
            if (req_valid && status.out_free) begin
               cmd.pass_load = 1'b1;
               if (req_last) begin
                  state_in = S_COLLECT;
                  pos_in = '0;
                  ihl_in = '0;
                  cmd.sum_clear = 1'b1;
               end else if (pos_ff < PW'(icmp_echo_pkg::POSITION_LIMIT)) begin
                  pos_in = pos_ff + PW'(1);
               end
            end
         end
         S_DISCARD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_last) begin
                  state_in = S_COLLECT;
                  pos_in = '0;
                  ihl_in = '0;
                  cmd.sum_clear = 1'b1;
               end else if (pos_ff < PW'(icmp_echo_pkg::POSITION_LIMIT)) begin
                  pos_in = pos_ff + PW'(1);
               end
            end
         end
         S_CSUM: begin
            cmd.csum_load = 1'b1;
            idx_in   = '0;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (is_final_emit) begin
                  if (last_ff) begin
                     state_in = S_COLLECT;
                     pos_in = '0;
                     ihl_in = '0;
                     cmd.sum_clear = 1'b1;
                  end else begin
                     state_in = S_STREAM;
                  end
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         pos_ff   <= '0;
         ihl_ff   <= '0;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         ihl_ff   <= ihl_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
      end
   end

   // The output register is never loaded from two sources at once.
   a_single_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_load && cmd.pass_load))
      else $error("emit and pass load in the same cycle");

   // A beat is loaded only when the output register can take it.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load || cmd.pass_load) |-> status.out_free)
      else $error("output register overwritten");

   // The checksum cycle is always followed by the first buffer read.
   a_csum_then_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CSUM) |=> (state_ff == S_EMIT_RD && idx_ff == '0))
      else $error("checksum not followed by reply emission");

   // The emit index never runs past the buffered header.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT_WR) |-> ((PW'(idx_ff) < need_cur)
                                   && (need_cur <= PW'(icmp_echo_pkg::HEADER_WORDS))))
      else $error("emit index beyond header");

   // No input beat is taken while the reply header is emitted.
   a_no_accept_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CSUM || state_ff == S_EMIT_RD || state_ff == S_EMIT_WR)
      |-> !req_ready)
      else $error("input accepted during reply emission");

endmodule

FILE: design/icmp_echo_reply_rewriter.sv
// ----------------------------------------------------------------------------
// ICMP echo reply rewriter
// Turns Ethernet/IPv4/ICMP echo requests into echo replies on a 16-bit
// word stream; all other frames are dropped.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries the incoming frame, one big-endian 16-bit word per beat,
//   frame_last on the final word and odd_tail when that word holds one byte.
//   rsp_ch carries the reply frame in the same format. The csr_ port holds
//   own_ip at byte address 0 and own_mac at byte address 8; write them while
//   no frame is in flight.
//   Header words (9 + 2*IHL of them, 19 to 39) are taken one per cycle and
//   stored in the header buffer. After the ICMP checksum word the IP header
//   checksum is computed and registered. Each reply header word is then read
//   through the buffer's registered read port and loaded into the output
//   register before the next word is read. Payload words then pass one per
//   cycle while the receiver takes them, registered in the output register.
//   A dropped frame produces no beats and is swallowed one word per cycle.
//   Reset clears the frame state and both address registers; the buffer
//   needs no clearing. When the receiver stalls, the output register holds
//   its beat, header emission pauses and payload input is back-pressured.
// ----------------------------------------------------------------------------
module icmp_echo_reply_rewriter (
   input  logic                                  clock,
   input  logic                                  reset,
   icmp_echo_req_if.sink                         req_ch,
   icmp_echo_rsp_if.source                       rsp_ch,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [icmp_echo_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [icmp_echo_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [icmp_echo_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);

   icmp_echo_pkg::cmd_type    cmd;
   icmp_echo_pkg::status_type status;
   logic [31:0]               own_ip;
   logic [47:0]               own_mac;

   // Address registers.
   icmp_echo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .own_ip  (own_ip),
      .own_mac (own_mac)
   );

   // Frame state machine.
   icmp_echo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_last  (req_ch.frame_last),
      .req_odd   (req_ch.odd_tail),
      .req_ihl   (req_ch.frame_word[11:8]),
      .cmd       (cmd),
      .status    (status)
   );

   // Header buffer, checksum and output register.
   icmp_echo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_ch.frame_word),
      .req_last  (req_ch.frame_last),
      .req_odd   (req_ch.odd_tail),
      .own_ip    (own_ip),
      .own_mac   (own_mac),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_word  (rsp_ch.reply_word),
      .rsp_last  (rsp_ch.reply_last),
      .rsp_odd   (rsp_ch.reply_odd_tail)
   );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICMP echo reply rewriter testbench
// Streams Ethernet/IPv4/ICMP frames into the rewriter and checks every reply
// beat against a built-in model of the rewrite. A directed set of frames is
// sent first, then four phases of random frames under different idle and
// stall patterns, with the own addresses rewritten between phases.
// ----------------------------------------------------------------------------
module tb;

   localparam int DRAIN_CYCLES     = 100;
   localparam int PHASE_WORDS_GOAL = 15;

   typedef struct packed {
      logic [15:0] word;
      logic        last;
      logic        odd;
      logic        hold;
   } frame_beat_type;

   typedef struct packed {
      logic [15:0] word;
      logic        last;
      logic        odd;
   } reply_beat_type;

   typedef enum logic [1:0] {RX_COLLECT, RX_STREAM, RX_DISCARD} rx_phase_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [icmp_echo_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [icmp_echo_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [icmp_echo_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   icmp_echo_req_if req_if ();
   icmp_echo_rsp_if rsp_if ();

   icmp_echo_reply_rewriter dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   // Stimulus and expected replies.
   frame_beat_type frame_beat_q[$];
   reply_beat_type pending_reply_q[$];
   frame_beat_type beat_in_flight;
   reply_beat_type seen_beat;
   reply_beat_type wanted_beat;
   int             send_idle_pct;
   int             recv_stall_pct;
   int             error_count;

   // Model state of the rewriter.
   logic [15:0]  hdr_copy [icmp_echo_pkg::HEADER_WORDS];
   int unsigned  word_pos;
   logic [3:0]   ihl_seen;
   logic [31:0]  ip_sum;
   rx_phase_type rx_phase;
   logic [31:0]  own_ip_m;
   logic [47:0]  own_mac_m;

   function automatic void start_frame();
      word_pos = 0;
      ihl_seen = '0;
      ip_sum   = '0;
      rx_phase = RX_COLLECT;
   endfunction

   function automatic void drop_current(input logic lst);
      if (lst) begin
         start_frame();
      end else begin
         rx_phase = RX_DISCARD;
      end
   endfunction

   // Build the reply header from the buffered request header.
   function automatic void emit_reply_header(input int unsigned need, input logic lst);
      logic [31:0] s;
      logic [15:0] csum;
      logic [15:0] v;
      logic [7:0]  hi;
      logic [7:0]  lo;
      int unsigned type_at;
      reply_beat_type r;
      type_at = icmp_echo_pkg::TYPE_BASE + 2 * int'(ihl_seen);
      s = ip_sum + own_ip_m[31:16] + own_ip_m[15:0]
          + hdr_copy[icmp_echo_pkg::POS_SRC_HI] + hdr_copy[icmp_echo_pkg::POS_SRC_LO];
      s = s[15:0] + (s >> 16);
      s = s[15:0] + (s >> 16);
      csum = ~s[15:0];
      for (int unsigned k = 0; k < need; k++) begin
         v = hdr_copy[k];
         if (k < icmp_echo_pkg::POS_MAC_SRC0) begin
            v = hdr_copy[k + icmp_echo_pkg::POS_MAC_SRC0];
         end else if (k <= icmp_echo_pkg::POS_MAC_SRC2) begin
            v = 16'(own_mac_m >> (16 * (icmp_echo_pkg::POS_MAC_SRC2 - k)));
         end else if (k == icmp_echo_pkg::POS_IP_CSUM) begin
            v = csum;
         end else if (k == icmp_echo_pkg::POS_SRC_HI) begin
            v = own_ip_m[31:16];
         end else if (k == icmp_echo_pkg::POS_SRC_LO) begin
            v = own_ip_m[15:0];
         end else if (k == icmp_echo_pkg::POS_DST_HI || k == icmp_echo_pkg::POS_DST_LO) begin
            v = hdr_copy[k - 2];
         end else if (k == type_at) begin
            v = {icmp_echo_pkg::ICMP_ECHO_REPLY, 8'h00};
         end else if (k == type_at + 1) begin
            // High byte moves up by the type change; carry lands in the low byte.
            hi = v[15:8];
            lo = v[7:0];
            if (hi > icmp_echo_pkg::CSUM_HI_LIMIT) begin
               lo = lo + 8'd1;
            end
            hi = hi + icmp_echo_pkg::CSUM_HI_INC;
            v = {hi, lo};
         end
         r.word = v;
         r.last = (k + 1 == need) ? lst : 1'b0;
         r.odd  = 1'b0;
         pending_reply_q.push_back(r);
      end
   endfunction

   // Advance the model by one accepted frame beat and queue its replies.
   function automatic void rewrite_beat(input frame_beat_type b);
      logic [15:0] w;
      logic        lst;
      logic        odd;
      int unsigned p;
      int unsigned need;
      reply_beat_type r;
      w   = b.word;
      lst = b.last;
      odd = b.odd & b.last;
      if (rx_phase == RX_STREAM) begin
         r.word = w;
         r.last = lst;
         r.odd  = odd;
         pending_reply_q.push_back(r);
         if (lst) begin
            start_frame();
         end else if (word_pos < icmp_echo_pkg::POSITION_LIMIT) begin
            word_pos++;
         end
         return;
      end
      if (rx_phase == RX_DISCARD) begin
         if (lst) begin
            start_frame();
         end else if (word_pos < icmp_echo_pkg::POSITION_LIMIT) begin
            word_pos++;
         end
         return;
      end
      p = word_pos;
      if (p < icmp_echo_pkg::HEADER_WORDS) begin
         hdr_copy[p] = w;
      end
      if (p == icmp_echo_pkg::POS_IHL) begin
         ihl_seen = w[11:8] & icmp_echo_pkg::IHL_MASK;
         if (ihl_seen < icmp_echo_pkg::MIN_IHL ||
             icmp_echo_pkg::NEED_BASE + 2 * int'(ihl_seen) > icmp_echo_pkg::HEADER_WORDS) begin
            drop_current(lst);
            return;
         end
      end
      if (p >= icmp_echo_pkg::POS_IHL) begin
         if (p < icmp_echo_pkg::TYPE_BASE + 2 * int'(ihl_seen) &&
             (p < icmp_echo_pkg::POS_IP_CSUM || p > icmp_echo_pkg::POS_DST_LO)) begin
            ip_sum = ip_sum + w;
         end
         need = icmp_echo_pkg::NEED_BASE + 2 * int'(ihl_seen);
         if (p + 1 == need) begin
            // A missing checksum byte or a type other than echo request drops the frame.
            if (odd || hdr_copy[need - 2][15:8] != icmp_echo_pkg::ICMP_ECHO_REQUEST) begin
               drop_current(lst);
               return;
            end
            emit_reply_header(need, lst);
            if (lst) begin
               start_frame();
            end else begin
               rx_phase = RX_STREAM;
               word_pos = p + 1;
            end
            return;
         end
      end
      if (lst) begin
         start_frame();
      end else begin
         word_pos = p + 1;
      end
   endfunction

   // Append one frame to the stimulus queue.
   function automatic void queue_frame(input logic [3:0] ihl_nib, input logic [7:0] type_byte,
                                       input logic [7:0] csum_hi, input int total,
                                       input logic odd_end, input fill_type fill,
                                       input logic hold);
      int type_at;
      frame_beat_type b;
      type_at = icmp_echo_pkg::TYPE_BASE + 2 * int'(ihl_nib);
      for (int i = 0; i < total; i++) begin
         case (fill)
            FILL_ZERO: b.word = '0;
            FILL_ONES: b.word = '1;
            default:   b.word = 16'($urandom);
         endcase
         if (i == icmp_echo_pkg::POS_IHL) begin
            b.word[11:8] = ihl_nib;
         end
         if (ihl_nib >= icmp_echo_pkg::MIN_IHL && i == type_at) begin
            b.word[15:8] = type_byte;
         end
         if (ihl_nib >= icmp_echo_pkg::MIN_IHL && i == type_at + 1) begin
            b.word[15:8] = csum_hi;
         end
         b.last = (i == total - 1);
         b.odd  = b.last ? odd_end : 1'($urandom_range(1));
         b.hold = hold && (i == 0);
         frame_beat_q.push_back(b);
      end
   endfunction

   function automatic void report_mismatch(input logic stray, input reply_beat_type want,
                                           input reply_beat_type got);
      error_count++;
      if (error_count <= 10) begin
         if (stray) begin
            $display("%0t: reply beat with none expected: word %h last %b odd %b",
                     $time, got.word, got.last, got.odd);
         end else begin
            $display("%0t: reply mismatch: expected word %h last %b odd %b,",
                     $time, want.word, want.last, want.odd,
                     " got word %h last %b odd %b", got.word, got.last, got.odd);
         end
      end
   endfunction

   // Frame driver: presents queued beats and hands each accepted beat to the model.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            rewrite_beat(beat_in_flight);
         end
         if (frame_beat_q.size() != 0 &&
             !(frame_beat_q[0].hold && pending_reply_q.size() != 0) &&
             $urandom_range(99) >= send_idle_pct) begin
            beat_in_flight = frame_beat_q.pop_front();
            req_if.valid      <= 1'b1;
            req_if.frame_word <= beat_in_flight.word;
            req_if.frame_last <= beat_in_flight.last;
            req_if.odd_tail   <= beat_in_flight.odd;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Reply monitor: stalls at random and checks each accepted beat in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_beat.word = rsp_if.reply_word;
            seen_beat.last = rsp_if.reply_last;
            seen_beat.odd  = rsp_if.reply_odd_tail;
            if (pending_reply_q.size() == 0) begin
               report_mismatch(1'b1, '0, seen_beat);
            end else begin
               wanted_beat = pending_reply_q.pop_front();
               if (wanted_beat.word !== seen_beat.word || wanted_beat.last !== seen_beat.last ||
                   wanted_beat.odd !== seen_beat.odd) begin
                  report_mismatch(1'b0, wanted_beat, seen_beat);
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Register write through the setup and access cycles.
   task automatic csr_write(input logic idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == icmp_echo_pkg::REG_OWN_IP) begin
         own_ip_m = value[31:0];
      end else begin
         own_mac_m = value[47:0];
      end
   endtask

   // Wait until every queued beat went in and every reply came out.
   task automatic wait_for_quiet();
      while (frame_beat_q.size() != 0 || req_if.valid || pending_reply_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Run limit.
   initial begin
      #2400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Main sequence.
   initial begin
      int          send_pct [4] = '{0, 80, 0, 29};
      int          recv_pct [4] = '{0, 0, 80, 29};
      int          phase_words;
      int          frames;
      int          roll;
      int          need;
      int          payload;
      int          total;
      logic [3:0]  ihl_nib;
      logic [7:0]  csum_hi;
      logic [7:0]  odd_type;
      logic        hold;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.frame_word  = '0;
      req_if.frame_last  = 1'b0;
      req_if.odd_tail    = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      error_count        = 0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      own_ip_m           = '0;
      own_mac_m          = '0;
      start_frame();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with all-ones addresses; upper data bits are junk.
      csr_write(icmp_echo_pkg::REG_OWN_IP, '1);
      csr_write(icmp_echo_pkg::REG_OWN_MAC, '1);
      // Plain echo request with an even payload.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'h12, 21, 1'b0, FILL_RANDOM, 1'b0);
      // Payload ends on a single byte; highest checksum byte without carry.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'hF7, 24, 1'b1, FILL_ZERO, 1'b0);
      // Reply ends at the checksum word; checksum byte carries.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'hF8, 19, 1'b0, FILL_ONES, 1'b0);
      // Longest header, checksum high byte wraps.
      queue_frame(4'd15, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'hFF, 41, 1'b0, FILL_ONES, 1'b0);
      // Not an echo request.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REPLY, 8'h00, 19, 1'b0, FILL_RANDOM, 1'b0);
      // Frame ends before the header is complete.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'h00, 12, 1'b0, FILL_RANDOM, 1'b0);
      // Zero header length, frame ends on the length word.
      queue_frame(4'd0, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'h00, 8, 1'b0, FILL_ZERO, 1'b0);
      // Short header followed by a discarded tail ending on one byte.
      queue_frame(4'd4, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'h00, 12, 1'b1, FILL_ONES, 1'b0);
      // Checksum word is the last word and holds a single byte.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'h40, 19, 1'b1, FILL_RANDOM, 1'b0);
      // Single-word frame.
      queue_frame(4'd5, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'h00, 1, 1'b1, FILL_RANDOM, 1'b0);
      // Recovery after drops, sent only once the block has gone quiet.
      queue_frame(4'd6, icmp_echo_pkg::ICMP_ECHO_REQUEST, 8'hF9, 22, 1'b1, FILL_RANDOM, 1'b1);
      wait_for_quiet();

      // Random phases under different idle patterns and address settings.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               csr_write(icmp_echo_pkg::REG_OWN_IP, '0);
               csr_write(icmp_echo_pkg::REG_OWN_MAC, '0);
            end
            3: begin
               csr_write(icmp_echo_pkg::REG_OWN_IP, 64'h0000_0000_FFFF_FFFF);
               csr_write(icmp_echo_pkg::REG_OWN_MAC, {$urandom, $urandom});
            end
            default: begin
               csr_write(icmp_echo_pkg::REG_OWN_IP, {$urandom, $urandom});
               csr_write(icmp_echo_pkg::REG_OWN_MAC, {$urandom, $urandom});
            end
         endcase
         send_idle_pct  = send_pct[ph];
         recv_stall_pct = recv_pct[ph];
         phase_words = 0;
         frames = 0;
         while (phase_words < PHASE_WORDS_GOAL) begin
            roll    = $urandom_range(99);
            ihl_nib = ($urandom_range(3) == 0) ? 4'($urandom_range(7, 15))
                                               : 4'($urandom_range(5, 6));
            need    = icmp_echo_pkg::NEED_BASE + 2 * int'(ihl_nib);
            payload = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            csum_hi = ($urandom_range(3) == 0) ? 8'($urandom_range(8'hF6, 8'hFF))
                                               : 8'($urandom);
            hold    = (frames == 1) || ($urandom_range(15) == 0);
            if (roll < 70) begin
               total = need + payload;
               queue_frame(ihl_nib, icmp_echo_pkg::ICMP_ECHO_REQUEST, csum_hi, total,
                           1'($urandom_range(1)), FILL_RANDOM, hold);
            end else if (roll < 80) begin
               odd_type = 8'($urandom);
               if (odd_type == icmp_echo_pkg::ICMP_ECHO_REQUEST) begin
                  odd_type = icmp_echo_pkg::ICMP_ECHO_REPLY;
               end
               total = need + payload;
               queue_frame(ihl_nib, odd_type, csum_hi, total,
                           1'($urandom_range(1)), FILL_RANDOM, hold);
            end else if (roll < 88) begin
               total = $urandom_range(1, need - 1);
               queue_frame(ihl_nib, icmp_echo_pkg::ICMP_ECHO_REQUEST, csum_hi, total,
                           1'($urandom_range(1)), FILL_RANDOM, hold);
            end else if (roll < 94) begin
               total = $urandom_range(1, 45);
               queue_frame(4'($urandom_range(0, 4)), icmp_echo_pkg::ICMP_ECHO_REQUEST, csum_hi,
                           total, 1'($urandom_range(1)), FILL_RANDOM, hold);
            end else begin
               total = need;
               queue_frame(ihl_nib, icmp_echo_pkg::ICMP_ECHO_REQUEST, csum_hi, total, 1'b1,
                           FILL_RANDOM, hold);
            end
            phase_words += total;
            frames++;
         end
         wait_for_quiet();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/icmp_echo_pkg.sv
design/icmp_echo_req_if.sv
design/icmp_echo_rsp_if.sv
design/icmp_echo_csr.sv
design/icmp_echo_dp.sv
design/icmp_echo_ctrl.sv
design/icmp_echo_reply_rewriter.sv
tb/sv/tb.sv
